[sv/ddo_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared beat types and register indexes for the odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_DIAMETER = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_DIAMETER  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_AXLE       = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_PERIOD     = 8'd3;

    typedef struct packed {
        logic signed [31:0] right_wheel_angle;
        logic signed [31:0] left_wheel_angle;
    } t_in;

    typedef struct packed {
        logic signed [31:0] travel_position;
        logic signed [31:0] rotation_position;
        logic signed [31:0] travel_speed;
        logic signed [31:0] rotation_speed;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [18:0] heading_angle;
    } t_out;

    typedef struct packed {
        logic start;
    } t_unit_ctl;

    typedef struct packed {
        logic done;
    } t_unit_sts;

endpackage
`default_nettype wire

[sv/ddo_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_mul
// Bit-serial signed multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ddo_mul #(
    parameter int AW = 34,
    parameter int BW = 33
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire ddo_pkg::t_unit_ctl  i_ctl,
    input  wire  logic signed [AW-1:0] i_a,
    input  wire  logic signed [BW-1:0] i_b,
    output ddo_pkg::t_unit_sts       o_sts,
    output logic signed [AW+BW-1:0]  o_p
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic signed [AW-1:0] r_a;
    logic        [BW-1:0] r_b;
    logic signed [PW-1:0] r_acc, n_acc, addend;
    logic        [CW-1:0] r_cnt;
    logic                 r_busy, r_done;

    always_comb begin
        // sign bit of the multiplier carries negative weight
        if (r_b[BW-1]) begin
            if (r_cnt == CW'(BW)) addend = -PW'(r_a);
            else                  addend = PW'(r_a);
        end else begin
            addend = '0;
        end
        n_acc = (r_acc <<< 1) + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= r_b << 1;
            r_acc <= n_acc;
        end
    end

    assign o_sts.done = r_done;
    assign o_p        = r_acc;
endmodule
`default_nettype wire

[sv/ddo_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC at Q30, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ddo_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire ddo_pkg::t_unit_ctl  i_ctl,
    input  wire  logic signed [35:0] i_angle,
    output ddo_pkg::t_unit_sts       o_sts,
    output logic signed [33:0]       o_cos,
    output logic signed [33:0]       o_sin
);
    localparam int NS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032875;

    function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
        logic signed [35:0] v;
        case (idx)
            5'd0:  v = 36'sd843314857;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043837;
            5'd3:  v = 36'sd133525159;
            5'd4:  v = 36'sd67021687;
            5'd5:  v = 36'sd33543516;
            5'd6:  v = 36'sd16775851;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194283;
            5'd9:  v = 36'sd2097149;
            default: v = 36'sd1048576 >>> (idx - 5'd10);
        endcase
        return v;
    endfunction

    logic signed [33:0] r_x, r_y, xs, ys;
    logic signed [35:0] r_z, z0, z1;
    logic        [4:0]  r_i;
    logic               r_busy, r_done, r_neg, neg0;

    always_comb begin
        z0   = i_angle;
        neg0 = 1'b0;
        if (z0 > PI_Q30) z0 = z0 - (PI_Q30 <<< 1);
        z1 = z0;
        if (z0 > HALF_PI_Q30) begin
            z1   = z0 - PI_Q30;
            neg0 = 1'b1;
        end else if (z0 < -HALF_PI_Q30) begin
            z1   = z0 + PI_Q30;
            neg0 = 1'b1;
        end
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == 5'(NS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x   <= GAIN_Q30;
            r_y   <= '0;
            r_z   <= z1;
            r_neg <= neg0;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_q30(r_i);
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_q30(r_i);
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_cos = r_neg ? -r_x : r_x;
    assign o_sin = r_neg ? -r_y : r_y;
endmodule
`default_nettype wire

[sv/differential_drive_odometry_core.sv]
// Each accepted input beat runs five products on the serial multiplier, the
// heading remainder, the CORDIC, two more products on the serial multiplier
// and one load into the output register.
// One tick at a time; the next input beat is taken the cycle after the result
// is loaded into the output register.
// Reset (synchronous, active low) restores register defaults and clears state.
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_odometry_core
// Dead-reckoning odometry for a differential-drive base, Q16.16 saturating.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core #(
    parameter int FRACTION_BITS = 16,
    parameter int CORDIC_STEPS  = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire ddo_pkg::t_in                     i_in_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output ddo_pkg::t_out                         o_out_data,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  logic [ddo_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire  logic [ddo_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam logic [63:0] TWO_PI_WIDE =
        (64'd26986075410 + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
    localparam logic [31:0] TWO_PI = TWO_PI_WIDE[31:0];

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MR   = 4'd1;
    localparam logic [3:0] S_ML   = 4'd2;
    localparam logic [3:0] S_MROT = 4'd3;
    localparam logic [3:0] S_MTS  = 4'd4;
    localparam logic [3:0] S_MRS  = 4'd5;
    localparam logic [3:0] S_MOD  = 4'd6;
    localparam logic [3:0] S_COR  = 4'd7;
    localparam logic [3:0] S_MX   = 4'd8;
    localparam logic [3:0] S_MY   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)        r = 32'sh7FFFFFFF;
        else if (v < -68'sd2147483648)  r = 32'sh80000000;
        else                            r = v[31:0];
        return r;
    endfunction

    logic [19:0] r_rwd, r_lwd;
    logic [30:0] r_iad, r_itp;
    logic signed [31:0] r_last_travel, r_last_rot, r_xacc, r_yacc;
    logic signed [31:0] r_la, r_r, r_travel, r_rot, r_tspeed, r_rspeed;
    logic signed [32:0] r_dt;
    logic [3:0]  r_state;
    logic [5:0]  r_cnt;
    logic [31:0] r_mag, r_rem, r_heading;
    logic        r_neg;
    logic        r_ov;
    ddo_pkg::t_out r_out;

    ddo_pkg::t_unit_ctl mul_ctl, cor_ctl;
    ddo_pkg::t_unit_sts mul_sts, cor_sts;
    logic signed [33:0] r_ma;
    logic signed [32:0] r_mb;
    logic signed [66:0] mul_p;
    logic signed [66:0] p_shf;
    logic signed [31:0] p_sat;
    logic signed [33:0] cor_c, cor_s;
    logic signed [35:0] cor_angle;
    logic               r_mul_start, r_cor_start;

    logic signed [32:0] sum_rl, dif_rl;
    logic signed [31:0] n_travel;
    logic        [32:0] rem_sh;
    logic signed [67:0] acc_sum;

    assign mul_ctl.start = r_mul_start;
    assign cor_ctl.start = r_cor_start;

    ddo_mul #(.AW(34), .BW(33)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (mul_ctl),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .o_sts  (mul_sts),
        .o_p    (mul_p)
    );

    assign cor_angle = $signed({4'b0, r_heading} << (30 - FRACTION_BITS));

    ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (cor_ctl),
        .i_angle(cor_angle),
        .o_sts  (cor_sts),
        .o_cos  (cor_c),
        .o_sin  (cor_s)
    );

    always_comb begin
        p_shf    = mul_p >>> FRACTION_BITS;
        p_sat    = sat32(68'(p_shf));
        sum_rl   = 33'(r_r) + 33'(p_sat);
        dif_rl   = 33'(r_r) - 33'(p_sat);
        n_travel = sum_rl[32:1];
        rem_sh   = {r_rem, r_mag[31]};
        acc_sum  = 68'(mul_p >>> 30) +
                   68'(r_state == S_MX ? r_xacc : r_yacc);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwd         <= 20'd65536;
            r_lwd         <= 20'd65536;
            r_iad         <= 31'd65536;
            r_itp         <= 31'd65536;
            r_last_travel <= '0;
            r_last_rot    <= '0;
            r_xacc        <= '0;
            r_yacc        <= '0;
            r_state       <= S_IDLE;
            r_mul_start   <= 1'b0;
            r_cor_start   <= 1'b0;
            r_ov          <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_mul_start <= 1'b0;
            r_cor_start <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ddo_pkg::CFG_RIGHT_DIAMETER: r_rwd <= i_cfg_data[19:0];
                    ddo_pkg::CFG_LEFT_DIAMETER:  r_lwd <= i_cfg_data[19:0];
                    ddo_pkg::CFG_INV_AXLE:       r_iad <= i_cfg_data[30:0];
                    ddo_pkg::CFG_INV_PERIOD:     r_itp <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            // the output load below takes over the valid flag
            if (r_ov && i_out_ready && r_state != S_OUT) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_la        <= i_in_data.left_wheel_angle;
                    r_ma        <= 34'(r_rwd);
                    r_mb        <= 33'(i_in_data.right_wheel_angle);
                    r_mul_start <= 1'b1;
                    r_state     <= S_MR;
                end
                S_MR: if (mul_sts.done) begin
                    r_r         <= p_sat;
                    r_ma        <= 34'(r_lwd);
                    r_mb        <= 33'(r_la);
                    r_mul_start <= 1'b1;
                    r_state     <= S_ML;
                end
                S_ML: if (mul_sts.done) begin
                    r_travel    <= n_travel;
                    r_dt        <= 33'(n_travel) - 33'(r_last_travel);
                    r_ma        <= 34'(r_iad);
                    r_mb        <= dif_rl;
                    r_mul_start <= 1'b1;
                    r_state     <= S_MROT;
                end
                S_MROT: if (mul_sts.done) begin
                    r_rot       <= p_sat;
                    r_ma        <= 34'(r_itp);
                    r_mb        <= r_dt;
                    r_mul_start <= 1'b1;
                    r_state     <= S_MTS;
                end
                S_MTS: if (mul_sts.done) begin
                    r_tspeed    <= p_sat;
                    r_mb        <= 33'(r_rot) - 33'(r_last_rot);
                    r_mul_start <= 1'b1;
                    r_state     <= S_MRS;
                end
                S_MRS: if (mul_sts.done) begin
                    r_rspeed <= p_sat;
                    r_neg    <= r_rot[31];
                    r_mag    <= r_rot[31] ? 32'(-33'(r_rot)) : r_rot;
                    r_rem    <= '0;
                    r_cnt    <= 6'd32;
                    r_state  <= S_MOD;
                end
                S_MOD: begin
                    // shift in one dividend bit, subtract when it fits
                    if (r_cnt != 6'd0) begin
                        r_mag <= r_mag << 1;
                        r_cnt <= r_cnt - 1'b1;
                        if (rem_sh >= 33'(TWO_PI)) r_rem <= 32'(rem_sh - 33'(TWO_PI));
                        else                       r_rem <= rem_sh[31:0];
                    end else begin
                        r_heading   <= (r_neg && r_rem != 32'd0) ? TWO_PI - r_rem : r_rem;
                        r_cor_start <= 1'b1;
                        r_state     <= S_COR;
                    end
                end
                S_COR: if (cor_sts.done) begin
                    r_ma        <= cor_c;
                    r_mb        <= r_dt;
                    r_mul_start <= 1'b1;
                    r_state     <= S_MX;
                end
                S_MX: if (mul_sts.done) begin
                    r_xacc      <= sat32(acc_sum);
                    r_ma        <= cor_s;
                    r_mul_start <= 1'b1;
                    r_state     <= S_MY;
                end
                S_MY: if (mul_sts.done) begin
                    r_yacc  <= sat32(acc_sum);
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_ov || i_out_ready) begin
                    r_out.travel_position   <= r_travel;
                    r_out.rotation_position <= r_rot;
                    r_out.travel_speed      <= r_tspeed;
                    r_out.rotation_speed    <= r_rspeed;
                    r_out.pos_x             <= r_xacc;
                    r_out.pos_y             <= r_yacc;
                    r_out.heading_angle     <= r_heading[18:0];
                    r_ov          <= 1'b1;
                    r_last_travel <= r_travel;
                    r_last_rot    <= r_rot;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
